// ----- hw/rtl/b3_pkg.sv -----
// Shared types, constants and round functions for the BLAKE3 chunk compressor.
`default_nettype none
package b3_pkg;

   localparam int unsigned CHAIN_WORDS = 8;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned ROUNDS      = 7;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_CHAIN = 2'd1;
   localparam logic [1:0] OP_MSG   = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [1:0] KIND_HASH_LO = 2'd0;
   localparam logic [1:0] KIND_HASH_HI = 2'd1;
   localparam logic [1:0] KIND_BLOCK   = 2'd2;
   localparam logic [1:0] KIND_CHAIN   = 2'd3;

   localparam logic [6:0] FLAG_CHUNK_START = 7'd1;
   localparam logic [6:0] FLAG_CHUNK_END   = 7'd2;
   localparam logic [6:0] FLAG_PARENT      = 7'd4;
   localparam logic [6:0] FLAG_ROOT        = 7'd8;

   localparam logic [31:0] BLAKE_IV [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [3:0] MSG_PERM [16] = '{
      4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
      4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
   };

   typedef logic [15:0][31:0] words16_type;
   typedef logic [7:0][31:0]  words8_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] data;
      logic [2:0]  word_pair;
      logic [6:0]  hash_flags;
      logic        want_chain;
      logic        last_beat;
      logic [6:0]  final_block_len;
   } req_type;

   typedef struct packed {
      logic [63:0] out_data;
      logic [1:0]  out_kind;
      logic [2:0]  out_index;
      logic        out_last;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_IV,
      JOB_LOAD,
      JOB_BLOCK,
      JOB_FINAL
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      words16_type  block;
      logic [63:0]  counter;
      logic [6:0]   len;
      logic [6:0]   flags;
      logic         xof;
      logic         emit_hi;
      logic [1:0]   pair;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_EMIT
   } back_state_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic words16_type mix(input words16_type v, input int a, input int b,
                                       input int c, input int d,
                                       input logic [31:0] x, input logic [31:0] y);
      words16_type s;
      s = v;
      s[a] = s[a] + s[b] + x;
      s[d] = rotr(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d];
      s[b] = rotr(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b] + y;
      s[d] = rotr(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d];
      s[b] = rotr(s[b] ^ s[c], 7);
      return s;
   endfunction

   function automatic words16_type blake_round(input words16_type v, input words16_type m);
      words16_type s;
      s = v;
      s = mix(s, 0, 4, 8, 12, m[0], m[1]);
      s = mix(s, 1, 5, 9, 13, m[2], m[3]);
      s = mix(s, 2, 6, 10, 14, m[4], m[5]);
      s = mix(s, 3, 7, 11, 15, m[6], m[7]);
      s = mix(s, 0, 5, 10, 15, m[8], m[9]);
      s = mix(s, 1, 6, 11, 12, m[10], m[11]);
      s = mix(s, 2, 7, 8, 13, m[12], m[13]);
      s = mix(s, 3, 4, 9, 14, m[14], m[15]);
      return s;
   endfunction

   function automatic words16_type permute(input words16_type m);
      words16_type t;
      for (int i = 0; i < 16; i++) begin
         t[i] = m[MSG_PERM[i]];
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/b3_front.sv -----
// Front end: accepts transactions, assembles blocks and issues jobs to the queue.
`default_nettype none
module b3_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire b3_pkg::req_type req_item,
   input  wire logic            q_full,
   output logic                 q_push,
   output b3_pkg::job_type      q_job
);
   import b3_pkg::*;

   words16_type blk_ff, blk_in;
   logic [63:0] counter_ff, counter_in;
   logic [6:0]  flags_ff, flags_in;
   logic        first_ff, first_in;
   logic        chain_sup_ff, chain_sup_in;
   logic        xof_ff, xof_in;

   logic        accept;
   words16_type merged;
   words16_type padded;
   logic [6:0]  len_sat;
   logic [6:0]  pend_flags;
   logic [3:0]  word_sel;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign word_sel = {req_item.word_pair, 1'b0};
   assign len_sat  = (req_item.final_block_len > 7'(BLOCK_BYTES)) ? 7'(BLOCK_BYTES)
                                                                  : req_item.final_block_len;

   always_comb begin
      pend_flags = flags_ff;
      if (first_ff) begin
         if ((flags_ff & FLAG_PARENT) == 7'd0) pend_flags = pend_flags | FLAG_CHUNK_START;
         if (chain_sup_ff && (flags_ff & FLAG_CHUNK_START) == 7'd0) begin
            pend_flags = pend_flags & ~FLAG_CHUNK_START;
         end
      end
   end

   always_comb begin
      merged = blk_ff;
      merged[word_sel]        = req_item.data[31:0];
      merged[word_sel + 4'd1] = req_item.data[63:32];
      padded = merged;
      for (int j = 0; j < 64; j++) begin
         if (7'(j) >= len_sat) padded[j / 4][8 * (j % 4) +: 8] = 8'd0;
      end
   end

   always_comb begin
      blk_in       = blk_ff;
      counter_in   = counter_ff;
      flags_in     = flags_ff;
      first_in     = first_ff;
      chain_sup_in = chain_sup_ff;
      xof_in       = xof_ff;
      q_push       = 1'b0;
      q_job        = '0;
      q_job.counter = counter_ff;
      q_job.pair    = req_item.word_pair[1:0];
      q_job.emit_hi = chain_sup_ff;
      q_job.xof     = xof_ff;
      if (accept) begin
         case (req_item.opcode)
            OP_BEGIN: begin
               counter_in   = req_item.data;
               flags_in     = req_item.hash_flags;
               xof_in       = req_item.want_chain;
               blk_in       = '0;
               first_in     = 1'b1;
               chain_sup_in = 1'b0;
               q_push       = 1'b1;
               q_job.kind   = JOB_IV;
            end
            OP_CHAIN: begin
               if (!req_item.word_pair[2]) begin
                  chain_sup_in       = 1'b1;
                  q_push             = 1'b1;
                  q_job.kind         = JOB_LOAD;
                  q_job.block[0]     = req_item.data[31:0];
                  q_job.block[1]     = req_item.data[63:32];
               end
            end
            OP_MSG: begin
               blk_in = merged;
               if (req_item.last_beat) begin
                  q_push      = 1'b1;
                  q_job.kind  = JOB_FINAL;
                  q_job.block = padded;
                  q_job.len   = len_sat;
                  q_job.flags = ((flags_ff & FLAG_PARENT) == 7'd0) ?
                                (pend_flags | FLAG_CHUNK_END) : pend_flags;
                  first_in    = 1'b1;
                  blk_in      = '0;
               end else if (req_item.word_pair == 3'd7) begin
                  q_push      = 1'b1;
                  q_job.kind  = JOB_BLOCK;
                  q_job.block = merged;
                  q_job.len   = 7'(BLOCK_BYTES);
                  q_job.flags = pend_flags & ~FLAG_ROOT;
                  first_in    = 1'b0;
                  blk_in      = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff       <= '0;
         counter_ff   <= '0;
         flags_ff     <= '0;
         first_ff     <= 1'b1;
         chain_sup_ff <= 1'b0;
         xof_ff       <= 1'b0;
      end else begin
         blk_ff       <= blk_in;
         counter_ff   <= counter_in;
         flags_ff     <= flags_in;
         first_ff     <= first_in;
         chain_sup_ff <= chain_sup_in;
         xof_ff       <= xof_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/b3_job_queue.sv -----
// Small job queue between the front end and the compression back end.
`default_nettype none
module b3_job_queue #(
   parameter int unsigned Depth = b3_pkg::QUEUE_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire b3_pkg::job_type push_job,
   output logic                 full,
   input  wire logic            pop,
   output b3_pkg::job_type      head_job,
   output logic                 empty
);
   import b3_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   job_type        mem_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == CntW'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/b3_back.sv -----
// Back end: owns the chaining value, runs the rounds and serializes the results.
`default_nettype none
module b3_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire b3_pkg::job_type job,
   input  wire logic            q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output b3_pkg::rsp_type      rsp_item
);
   import b3_pkg::*;

   back_state_type state_ff, state_in;
   words8_type  cv_ff, cv_in;
   words8_type  hi_ff, hi_in;
   words16_type v_ff, v_in;
   words16_type msg_ff, msg_in;
   logic [2:0]  round_ff, round_in;
   logic [3:0]  beat_ff, beat_in;
   logic        final_ff, final_in;
   logic        xof_ff, xof_in;
   logic        emit_hi_ff, emit_hi_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   words16_type init_v;
   words16_type v_round;
   logic        slot_free;
   logic        last_beat;
   rsp_type     beat_item;
   logic [2:0]  bidx;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign last_beat = xof_ff ? (beat_ff == 4'd11) : (emit_hi_ff ? beat_ff == 4'd7
                                                                : beat_ff == 4'd3);

   always_comb begin
      for (int i = 0; i < 8; i++) init_v[i] = cv_ff[i];
      for (int i = 0; i < 4; i++) init_v[8 + i] = BLAKE_IV[i];
      init_v[12] = job.counter[31:0];
      init_v[13] = job.counter[63:32];
      init_v[14] = 32'(job.len);
      init_v[15] = 32'(job.flags);
      v_round    = blake_round(state_ff == BK_IDLE ? init_v : v_ff,
                               state_ff == BK_IDLE ? job.block : msg_ff);
   end

   // Beat selection for the result serializer.
   always_comb begin
      beat_item          = '0;
      beat_item.out_last = last_beat;
      bidx               = beat_ff[2:0];
      if (xof_ff) begin
         if (!beat_ff[3]) begin
            beat_item.out_kind = KIND_BLOCK;
            beat_item.out_data = {msg_ff[{bidx, 1'b1}], msg_ff[{bidx, 1'b0}]};
         end else begin
            beat_item.out_kind = KIND_CHAIN;
            beat_item.out_data = {cv_ff[{bidx[1:0], 1'b1}], cv_ff[{bidx[1:0], 1'b0}]};
         end
      end else if (!beat_ff[2]) begin
         beat_item.out_kind = KIND_HASH_LO;
         beat_item.out_data = {cv_ff[{bidx[1:0], 1'b1}], cv_ff[{bidx[1:0], 1'b0}]};
      end else begin
         beat_item.out_kind = KIND_HASH_HI;
         beat_item.out_data = {hi_ff[{bidx[1:0], 1'b1}], hi_ff[{bidx[1:0], 1'b0}]};
      end
      beat_item.out_index = xof_ff ? bidx : {1'b0, bidx[1:0]};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (job.kind == JOB_BLOCK) state_in = BK_RUN;
               else if (job.kind == JOB_FINAL) state_in = job.xof ? BK_EMIT : BK_RUN;
            end
         end
         BK_RUN: begin
            if (round_ff == 3'(ROUNDS - 1)) state_in = final_ff ? BK_EMIT : BK_IDLE;
         end
         BK_EMIT: begin
            if (slot_free && last_beat) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      q_pop        = 1'b0;
      cv_in        = cv_ff;
      hi_in        = hi_ff;
      v_in         = v_ff;
      msg_in       = msg_ff;
      round_in     = round_ff;
      beat_in      = beat_ff;
      final_in     = final_ff;
      xof_in       = xof_ff;
      emit_hi_in   = emit_hi_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (job.kind)
                  JOB_IV: begin
                     for (int i = 0; i < 8; i++) cv_in[i] = BLAKE_IV[i];
                  end
                  JOB_LOAD: begin
                     cv_in[{job.pair, 1'b0}] = job.block[0];
                     cv_in[{job.pair, 1'b1}] = job.block[1];
                  end
                  default: begin
                     final_in   = (job.kind == JOB_FINAL);
                     xof_in     = job.xof && (job.kind == JOB_FINAL);
                     emit_hi_in = job.emit_hi;
                     beat_in    = '0;
                     round_in   = 3'd1;
                     if (job.xof && job.kind == JOB_FINAL) begin
                        msg_in = job.block;
                     end else begin
                        v_in   = v_round;
                        msg_in = permute(job.block);
                     end
                  end
               endcase
            end
         end
         BK_RUN: begin
            v_in     = v_round;
            msg_in   = permute(msg_ff);
            round_in = round_ff + 3'd1;
            if (round_ff == 3'(ROUNDS - 1)) begin
               for (int i = 0; i < 8; i++) begin
                  cv_in[i] = v_round[i] ^ v_round[8 + i];
                  hi_in[i] = cv_ff[i] ^ v_round[8 + i];
               end
            end
         end
         BK_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in       = beat_item;
               beat_in      = beat_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      msg_ff     <= msg_in;
      hi_ff      <= hi_in;
      round_ff   <= round_in;
      out_ff     <= out_in;
      beat_ff    <= beat_in;
      final_ff   <= final_in;
      xof_ff     <= xof_in;
      emit_hi_ff <= emit_hi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= BLAKE_IV[i];
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cv_ff        <= cv_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/blake3_chunk_compressor.sv -----
// Top level of the BLAKE3 chunk compressor: front end, job queue and back end.
//
// Input transactions arrive on a queue-style port: one is taken at a clock
// edge where req_push is high and req_full is low. A begin transaction sets
// the counter, flags and mode; chain transactions overwrite chaining words;
// message transactions carry eight bytes each, eight of them fill a block.
// The front end takes one transaction per cycle while req_full is low and
// turns every completed block, begin and in-range chain load into a job for
// a short queue. The back end owns the chaining value and runs one BLAKE3
// round per cycle; the cycle that pops a block job also runs the first round.
// That keeps up with the message beats needed to fill the next block.
// Results leave on a queue-style port: the oldest result sits on rsp_item
// while rsp_empty is low and is taken when rsp_pop is high. A final beat
// produces 4 or 8 hash beats, or 12 beats in XOF mode, one per cycle while the
// output slot is free; in XOF mode the rounds are skipped.
// When the receiver stalls, the output register holds, the back end waits,
// the queue fills and req_full is raised. Synchronous reset empties the
// queue and loads the IV into the chaining value.
`default_nettype none
module blake3_chunk_compressor #(
   parameter int unsigned QueueDepth = b3_pkg::QUEUE_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire b3_pkg::req_type req_item,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output b3_pkg::rsp_type      rsp_item
);
   import b3_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   job_type push_job, head_job;

   b3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   b3_job_queue #(.Depth(QueueDepth)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   b3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

// ----- sim/blake3_chunk_compressor_tb.sv -----
// Self-checking testbench for the BLAKE3 chunk compressor with a built-in hash predictor.
`default_nettype none
module blake3_chunk_compressor_tb;
   import b3_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned MAX_REPORTS = 10;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_item;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_item;

   blake3_chunk_compressor uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   // Hash predictor state. It mirrors the block's chaining value, the block
   // being assembled, the call settings and the compression working vector.
   logic [31:0] chain_words [8];
   logic [31:0] blk_words [16];
   logic [31:0] wv [16];
   logic [31:0] msg_buf [16];
   logic [31:0] upper_half [8];
   logic [63:0] block_ctr;
   logic [6:0]  call_fl;
   logic        first_pending;
   logic        chain_given;
   logic        xof_on;

   // Result beats that the predictor says must still come out, oldest first.
   rsp_type     expected_beats [$];

   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_cycles;

   // The clock runs with a period of 20 time units.
   initial begin
      clock = 1'b0;
      forever begin
         #10 clock = ~clock;
      end
   end

   // A generous watchdog. A correct run finishes far below this count, even
   // with every result waiting out the receiver's worst stall.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // One quarter-round of the BLAKE3 G function on the working vector.
   function automatic void g_mix(input int a, input int b, input int c, input int d,
                                 input logic [31:0] x, input logic [31:0] y);
      wv[a] = wv[a] + wv[b] + x;
      wv[d] = ror32(wv[d] ^ wv[a], 16);
      wv[c] = wv[c] + wv[d];
      wv[b] = ror32(wv[b] ^ wv[c], 12);
      wv[a] = wv[a] + wv[b] + y;
      wv[d] = ror32(wv[d] ^ wv[a], 8);
      wv[c] = wv[c] + wv[d];
      wv[b] = ror32(wv[b] ^ wv[c], 7);
   endfunction

   // Compresses msg_buf into the chaining value. The old chaining value XOR
   // the upper half of the final working vector lands in upper_half.
   function automatic void model_compress(input logic [31:0] len, input logic [6:0] fl);
      logic [31:0] m [16];
      logic [31:0] t [16];
      for (int i = 0; i < 16; i++) begin
         m[i] = msg_buf[i];
      end
      for (int i = 0; i < 8; i++) begin
         wv[i] = chain_words[i];
      end
      for (int i = 0; i < 4; i++) begin
         wv[8 + i] = BLAKE_IV[i];
      end
      wv[12] = block_ctr[31:0];
      wv[13] = block_ctr[63:32];
      wv[14] = len;
      wv[15] = {25'd0, fl};
      for (int r = 0; r < ROUNDS; r++) begin
         g_mix(0, 4, 8, 12, m[0], m[1]);
         g_mix(1, 5, 9, 13, m[2], m[3]);
         g_mix(2, 6, 10, 14, m[4], m[5]);
         g_mix(3, 7, 11, 15, m[6], m[7]);
         g_mix(0, 5, 10, 15, m[8], m[9]);
         g_mix(1, 6, 11, 12, m[10], m[11]);
         g_mix(2, 7, 8, 13, m[12], m[13]);
         g_mix(3, 4, 9, 14, m[14], m[15]);
         for (int i = 0; i < 16; i++) begin
            t[i] = m[MSG_PERM[i]];
         end
         for (int i = 0; i < 16; i++) begin
            m[i] = t[i];
         end
      end
      for (int i = 0; i < 8; i++) begin
         upper_half[i]  = chain_words[i] ^ wv[8 + i];
         chain_words[i] = wv[i] ^ wv[8 + i];
      end
   endfunction

   // Flags of the block about to be compressed. A first block gets
   // CHUNK_START unless it is a parent node, but a supplied chain takes it
   // away again when the call itself did not ask for it.
   function automatic logic [6:0] next_block_flags();
      logic [6:0] f;
      f = call_fl;
      if (first_pending) begin
         if ((call_fl & FLAG_PARENT) == 7'd0) f = f | FLAG_CHUNK_START;
         if (chain_given && (call_fl & FLAG_CHUNK_START) == 7'd0) f = f & ~FLAG_CHUNK_START;
      end
      return f;
   endfunction

   function automatic void expect_beat(input logic [31:0] lo, input logic [31:0] hi,
                                       input logic [1:0] kind, input int idx,
                                       input logic last);
      rsp_type b;
      b.out_data  = {hi, lo};
      b.out_kind  = kind;
      b.out_index = idx[2:0];
      b.out_last  = last;
      expected_beats.push_back(b);
   endfunction

   function automatic void clear_block();
      for (int i = 0; i < 16; i++) begin
         blk_words[i] = 32'd0;
      end
   endfunction

   function automatic void reset_hash_model();
      for (int i = 0; i < 8; i++) begin
         chain_words[i] = BLAKE_IV[i];
      end
      clear_block();
      block_ctr     = 64'd0;
      call_fl       = 7'd0;
      first_pending = 1'b1;
      chain_given   = 1'b0;
      xof_on        = 1'b0;
   endfunction

   // Advances the predictor by one accepted transaction and queues the
   // result beats it causes.
   function automatic void hash_model_step(input req_type it);
      int unsigned p;
      logic [31:0] len;
      logic [31:0] keep;
      logic [6:0]  fl;
      p = {29'd0, it.word_pair};
      case (it.opcode)
         OP_BEGIN: begin
            block_ctr = it.data;
            call_fl   = it.hash_flags;
            xof_on    = it.want_chain;
            for (int i = 0; i < 8; i++) begin
               chain_words[i] = BLAKE_IV[i];
            end
            clear_block();
            first_pending = 1'b1;
            chain_given   = 1'b0;
         end
         OP_CHAIN: begin
            // Only the four pairs of the chaining value exist; others are dropped.
            if (p < 4) begin
               chain_words[2 * p]     = it.data[31:0];
               chain_words[2 * p + 1] = it.data[63:32];
               chain_given = 1'b1;
            end
         end
         OP_MSG: begin
            blk_words[2 * p]     = it.data[31:0];
            blk_words[2 * p + 1] = it.data[63:32];
            if (!it.last_beat) begin
               if (p == 7) begin
                  for (int i = 0; i < 16; i++) begin
                     msg_buf[i] = blk_words[i];
                  end
                  model_compress(BLOCK_BYTES, next_block_flags() & ~FLAG_ROOT);
                  first_pending = 1'b0;
                  clear_block();
               end
            end else begin
               // Lengths above a full block saturate; bytes past the length are zeroed.
               len = (it.final_block_len > 7'd64) ? 32'd64 : {25'd0, it.final_block_len};
               for (int i = 0; i < 16; i++) begin
                  if (len >= 4 * i + 4) keep = 32'hFFFF_FFFF;
                  else if (len <= 4 * i) keep = 32'd0;
                  else keep = (32'd1 << (8 * (len - 4 * i))) - 32'd1;
                  msg_buf[i] = blk_words[i] & keep;
               end
               fl = next_block_flags();
               if ((call_fl & FLAG_PARENT) == 7'd0) fl = fl | FLAG_CHUNK_END;
               if (xof_on) begin
                  for (int i = 0; i < 8; i++) begin
                     expect_beat(msg_buf[2 * i], msg_buf[2 * i + 1], KIND_BLOCK, i, 1'b0);
                  end
                  for (int i = 0; i < 4; i++) begin
                     expect_beat(chain_words[2 * i], chain_words[2 * i + 1], KIND_CHAIN, i,
                                 i == 3);
                  end
               end else begin
                  model_compress(len, fl);
                  for (int i = 0; i < 4; i++) begin
                     expect_beat(chain_words[2 * i], chain_words[2 * i + 1], KIND_HASH_LO, i,
                                 i == 3 && !chain_given);
                  end
                  if (chain_given) begin
                     for (int i = 0; i < 4; i++) begin
                        expect_beat(upper_half[2 * i], upper_half[2 * i + 1], KIND_HASH_HI, i,
                                    i == 3);
                     end
                  end
               end
               first_pending = 1'b1;
               clear_block();
            end
         end
         default: begin
            // The unused opcode leaves the block untouched.
         end
      endcase
   endfunction

   // Receiver side: pops at random, honors a long hold-off when one is
   // requested, and checks every accepted result transaction against the
   // oldest expected beat.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_beats.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < MAX_REPORTS)
                  $display("unexpected result: data %h kind %0d index %0d last %0d",
                           rsp_item.out_data, rsp_item.out_kind, rsp_item.out_index,
                           rsp_item.out_last);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_item.out_data !== want.out_data || rsp_item.out_kind !== want.out_kind ||
                   rsp_item.out_index !== want.out_index ||
                   rsp_item.out_last !== want.out_last) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < MAX_REPORTS)
                     $display("result mismatch: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                              want.out_data, want.out_kind, want.out_index, want.out_last,
                              rsp_item.out_data, rsp_item.out_kind, rsp_item.out_index,
                              rsp_item.out_last);
               end
            end
         end
         if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_pop     <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Builds a transaction whose unused fields carry random bits.
   function automatic req_type make_item(input logic [1:0] op, input logic [63:0] data,
                                         input logic [2:0] pair, input logic last,
                                         input logic [6:0] len);
      req_type it;
      it.opcode          = op;
      it.data            = data;
      it.word_pair       = pair;
      it.hash_flags      = 7'($urandom_range(0, 127));
      it.want_chain      = 1'($urandom_range(0, 1));
      it.last_beat       = last;
      it.final_block_len = len;
      return it;
   endfunction

   // Offers one transaction, with an optional random gap first, and waits
   // until the block takes it. Push stays high afterwards so that back-to-back
   // transactions follow one another without an idle gap.
   task automatic send_item(input req_type it);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      hash_model_step(it);
   endtask

   task automatic send_begin(input logic [63:0] ctr, input logic [6:0] fl, input logic xof);
      req_type it;
      it = make_item(OP_BEGIN, ctr, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     7'($urandom_range(0, 127)));
      it.hash_flags = fl;
      it.want_chain = xof;
      send_item(it);
   endtask

   task automatic send_chain(input int pair);
      send_item(make_item(OP_CHAIN, rand64(), pair[2:0], 1'($urandom_range(0, 1)),
                          7'($urandom_range(0, 127))));
   endtask

   task automatic send_beat(input int pair, input logic last, input int len);
      send_item(make_item(OP_MSG, rand64(), pair[2:0], last,
                          last ? len[6:0] : 7'($urandom_range(0, 127))));
   endtask

   task automatic send_full_block();
      for (int p = 0; p < 8; p++) begin
         send_beat(p, 1'b0, 0);
      end
   endtask

   // Stops offering transactions and waits until every expected beat is out.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   // Directed cases: empty and short blocks, saturated length, extreme
   // counter, parent flags, chain loads in and out of range, the unused
   // opcode, XOF mode and a message that follows another without a begin.
   task automatic test_directed();
      send_begin(64'd0, 7'd0, 1'b0);
      send_beat(0, 1'b1, 8);
      send_beat(3, 1'b1, 0);
      send_begin(64'hFFFF_FFFF_FFFF_FFFF, FLAG_PARENT | FLAG_ROOT, 1'b0);
      for (int p = 0; p < 4; p++) begin
         send_chain(p);
      end
      send_chain(5);
      send_item(make_item(OP_RSVD, rand64(), 3'd7, 1'b1, 7'd64));
      send_beat(7, 1'b1, 100);
      send_begin(64'd5, FLAG_CHUNK_START, 1'b1);
      send_chain(1);
      send_full_block();
      send_beat(0, 1'b1, 0);
      send_begin(rand64(), 7'h7F, 1'b0);
      send_beat(7, 1'b1, 127);
      wait_drained();
   endtask

   // One well-formed message with random content: usually a begin, maybe
   // some chain words, zero to two full blocks and a final block of random
   // shape. Returns the number of transactions sent.
   task automatic send_random_message(output int count);
      int unsigned pick;
      int          beats;
      int          len;
      count = 0;
      if ($urandom_range(0, 9) != 0) begin
         pick = $urandom_range(0, 3);
         send_begin(pick == 0 ? 64'd0 : pick == 1 ? 64'hFFFF_FFFF_FFFF_FFFF : rand64(),
                    7'($urandom_range(0, 127)), $urandom_range(0, 2) == 0);
         count++;
      end
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            send_chain($urandom_range(0, 3));
            count++;
         end
      end
      repeat ($urandom_range(0, 2)) begin
         send_full_block();
         count += 8;
      end
      beats = $urandom_range(1, 8);
      for (int p = 0; p < beats - 1; p++) begin
         send_beat(p, 1'b0, 0);
         count++;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) len = 0;
      else if (pick == 1) len = $urandom_range(65, 127);
      else len = beats * 8 - $urandom_range(0, 7);
      send_beat(beats - 1, 1'b1, len);
      count++;
   endtask

   // Random traffic: mostly well-formed messages, some stray transactions.
   task automatic test_random(input int target);
      int sent;
      int n;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(0, 19))
            0: send_item(make_item(OP_RSVD, rand64(), 3'($urandom_range(0, 7)),
                                   1'($urandom_range(0, 1)), 7'($urandom_range(0, 127))));
            1: send_chain($urandom_range(4, 7));
            2: begin
               send_beat($urandom_range(0, 7), 1'b1, $urandom_range(0, 127));
               sent++;
            end
            default: begin
               send_random_message(n);
               sent += n;
            end
         endcase
      end
   endtask

   // The receiver stops for a long stretch while the sender keeps going, so
   // the output side backs up and req_full must stall the input. Then the
   // sender pauses until every expected beat has drained.
   task automatic test_backpressure();
      int n;
      hold_cycles = 400;
      send_begin(rand64(), 7'd0, 1'b0);
      send_chain(0);
      send_full_block();
      send_beat(7, 1'b1, 64);
      repeat (3) send_random_message(n);
      wait_drained();
   endtask

   initial begin
      reset         = 1'b1;
      req_push      = 1'b0;
      req_item      = '0;
      rsp_pop       = 1'b0;
      mismatches    = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 0;
      reset_hash_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      send_idle_pct = 30;
      recv_idle_pct = 77;
      test_random(80);
      send_idle_pct = 77;
      recv_idle_pct = 30;
      test_random(80);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(80);
      test_backpressure();

      // Allow any stray result to surface after the last expected beat.
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
